// ===== rtl/ccrc_pkg.sv =====
// Package for the configurable CRC engine: register map, reset values and bit helpers.
package ccrc_pkg;

    // Largest CRC width the datapath carries
    localparam int unsigned MAX_WIDTH = 64;

    // Field and bus widths
    localparam int unsigned CRC_W   = 64;
    localparam int unsigned CWID_W  = 7;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ADDR_W  = 6;
    localparam int unsigned PDATA_W = 64;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned BIT_W   = 6;

    // Register indexes; each register sits at byte address 8*index
    typedef enum logic [IDX_W-1:0] {
        REG_CRC_WIDTH      = 3'd0,
        REG_POLYNOMIAL     = 3'd1,
        REG_INITIAL_VALUE  = 3'd2,
        REG_REFLECT_INPUT  = 3'd3,
        REG_REFLECT_OUTPUT = 3'd4,
        REG_FINAL_XOR      = 3'd5
    } t_reg_idx;

    // Reset values (CRC-32 defaults)
    localparam logic [CWID_W-1:0] RST_CRC_WIDTH      = 7'd32;
    localparam logic [CRC_W-1:0]  RST_POLYNOMIAL     = 64'h0000_0000_04C1_1DB7;
    localparam logic [CRC_W-1:0]  RST_INITIAL_VALUE  = 64'h0000_0000_FFFF_FFFF;
    localparam logic              RST_REFLECT_INPUT  = 1'b1;
    localparam logic              RST_REFLECT_OUTPUT = 1'b1;
    localparam logic [CRC_W-1:0]  RST_FINAL_XOR      = 64'h0000_0000_FFFF_FFFF;

    // Clamp the programmed width to 1..MAX_WIDTH
    function automatic logic [CWID_W-1:0] f_eff_width(input logic [CWID_W-1:0] cw);
        logic [CWID_W-1:0] w;
        w = cw;
        if (w == '0) begin
            w = CWID_W'(1);
        end
        if (w > CWID_W'(MAX_WIDTH)) begin
            w = CWID_W'(MAX_WIDTH);
        end
        return w;
    endfunction

    // Ones in the low w bits
    function automatic logic [CRC_W-1:0] f_mask(input logic [CWID_W-1:0] w);
        logic [CWID_W-1:0] sh;
        sh = CWID_W'(CRC_W) - w;
        return {CRC_W{1'b1}} >> sh;
    endfunction

    // Bit reverse over the low w bits; bits above w drop out
    function automatic logic [CRC_W-1:0] f_rev(input logic [CRC_W-1:0] v,
                                               input logic [CWID_W-1:0] w);
        logic [CRC_W-1:0]  r;
        logic [CWID_W-1:0] sh;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        sh = CWID_W'(CRC_W) - w;
        return r >> sh;
    endfunction

endpackage

// ===== rtl/configurable_crc_engine.sv =====
// Configurable CRC engine (Rocksoft-style CRC, width 1 to 64, one byte per word).
// Takes one message byte per clock, without bubbles while in_stall is low: the whole
// eight-bit register update is one pass of XOR logic from the running CRC register back
// into itself. On the word marked last, the raw CRC goes to the stage 1 register, then
// through the finishing logic (reflection and final XOR) into the output register.
// in_stall rises only when both result stages are full and out_stall holds the output.
// Settings are written over the APB port at byte address 8*index; any write to a known
// register restarts the running CRC from the start value under the new settings. The
// user must change registers only while no message result is outstanding; the block
// itself does not enforce this.
module configurable_crc_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ccrc_pkg::ADDR_W-1:0]    paddr,
    input  logic [ccrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [ccrc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // byte input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ccrc_pkg::DATA_W-1:0]    i_data_byte,
    input  logic                           i_last_byte,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ccrc_pkg::CRC_W-1:0]     o_crc_value
);
    import ccrc_pkg::*;

    // Configuration registers
    logic [CWID_W-1:0] r_crc_width;
    logic [CRC_W-1:0]  r_polynomial;
    logic [CRC_W-1:0]  r_initial_value;
    logic              r_reflect_input;
    logic              r_reflect_output;
    logic [CRC_W-1:0]  r_final_xor;

    // Running CRC and its reload flag
    logic [CRC_W-1:0]  r_crc;
    logic              r_fresh;

    // Result stages
    logic              r_s1_valid;
    logic [CRC_W-1:0]  r_s1_crc;
    logic              r_out_valid;
    logic [CRC_W-1:0]  r_out_crc;

    logic              cfg_wr;
    logic              cfg_known;
    t_reg_idx          cfg_idx;
    logic              in_acc;
    logic              s1_adv;
    logic [CWID_W-1:0] eff_w;
    logic [BIT_W-1:0]  top_bit;
    logic [CRC_W-1:0]  mask;
    logic [CRC_W-1:0]  poly;
    logic [CRC_W-1:0]  rpoly;
    logic [CRC_W-1:0]  start_val;
    logic [CRC_W-1:0]  n_crc;
    logic [CRC_W-1:0]  fin_crc;

    // Register decode
    assign cfg_idx   = t_reg_idx'(paddr[ADDR_W-1:ADDR_W-IDX_W]);
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        cfg_known = 1'b1;
        prdata    = '0;
        unique case (cfg_idx)
            REG_CRC_WIDTH:      prdata = PDATA_W'(r_crc_width);
            REG_POLYNOMIAL:     prdata = r_polynomial;
            REG_INITIAL_VALUE:  prdata = r_initial_value;
            REG_REFLECT_INPUT:  prdata = PDATA_W'(r_reflect_input);
            REG_REFLECT_OUTPUT: prdata = PDATA_W'(r_reflect_output);
            REG_FINAL_XOR:      prdata = r_final_xor;
            default:            cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_width      <= RST_CRC_WIDTH;
            r_polynomial     <= RST_POLYNOMIAL;
            r_initial_value  <= RST_INITIAL_VALUE;
            r_reflect_input  <= RST_REFLECT_INPUT;
            r_reflect_output <= RST_REFLECT_OUTPUT;
            r_final_xor      <= RST_FINAL_XOR;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CRC_WIDTH:      r_crc_width      <= pwdata[CWID_W-1:0];
                REG_POLYNOMIAL:     r_polynomial     <= pwdata;
                REG_INITIAL_VALUE:  r_initial_value  <= pwdata;
                REG_REFLECT_INPUT:  r_reflect_input  <= pwdata[0];
                REG_REFLECT_OUTPUT: r_reflect_output <= pwdata[0];
                REG_FINAL_XOR:      r_final_xor      <= pwdata;
                default: ;
            endcase
        end
    end

    // Derived settings
    assign eff_w     = f_eff_width(r_crc_width);
    assign top_bit   = BIT_W'(eff_w - CWID_W'(1));
    assign mask      = f_mask(eff_w);
    assign poly      = r_polynomial & mask;
    assign rpoly     = f_rev(poly, eff_w);
    assign start_val = r_reflect_input ? f_rev(r_initial_value & mask, eff_w)
                                       : (r_initial_value & mask);

    // Handshake: stall only when both result stages are held
    assign s1_adv   = r_s1_valid && !(r_out_valid && out_stall);
    assign in_stall = r_s1_valid && r_out_valid && out_stall;
    assign in_acc   = in_valid && !in_stall;

    // Eight-bit CRC update
    always_comb begin
        logic [CRC_W-1:0] c;
        logic             fb;
        c = (r_fresh ? start_val : r_crc) & mask;
        if (r_reflect_input) begin
            c = c ^ CRC_W'(i_data_byte);
            for (int i = 0; i < DATA_W; i++) begin
                fb = c[0];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ rpoly;
                end
            end
        end else begin
            for (int i = 0; i < DATA_W; i++) begin
                fb = c[top_bit] ^ i_data_byte[DATA_W-1-i];
                c  = (c << 1) & mask;
                if (fb) begin
                    c = c ^ poly;
                end
            end
        end
        n_crc = c & mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
        end else if (cfg_wr && cfg_known) begin
            r_fresh <= 1'b1;
        end else if (in_acc) begin
            r_fresh <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_crc <= n_crc;
        end
    end

    // Stage 1: raw CRC of a finished message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_s1_crc <= n_crc;
        end
    end

    // Finishing: reflect when the two reflect settings differ, then final XOR
    assign fin_crc = (((r_reflect_input ^ r_reflect_output) ? f_rev(r_s1_crc, eff_w)
                                                            : r_s1_crc)
                      ^ r_final_xor) & mask;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_crc <= fin_crc;
        end
    end

    assign out_valid   = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the configurable CRC engine: directed and random byte streams.
`timescale 1ns / 1ps

// Tracks the engine's settings and running CRC, and holds the CRC words still owed
class crc_scoreboard;
    logic [ccrc_pkg::CWID_W-1:0] width_set;
    logic [63:0]                 poly_set;
    logic [63:0]                 init_set;
    logic                        refl_in_set;
    logic                        refl_out_set;
    logic [63:0]                 xor_set;
    logic [63:0]                 running_crc;
    logic [63:0]                 expected_crcs[$];
    int unsigned                 fail_count;
    int unsigned                 words_seen;

    function new();
        width_set    = ccrc_pkg::RST_CRC_WIDTH;
        poly_set     = ccrc_pkg::RST_POLYNOMIAL;
        init_set     = ccrc_pkg::RST_INITIAL_VALUE;
        refl_in_set  = ccrc_pkg::RST_REFLECT_INPUT;
        refl_out_set = ccrc_pkg::RST_REFLECT_OUTPUT;
        xor_set      = ccrc_pkg::RST_FINAL_XOR;
        fail_count   = 0;
        words_seen   = 0;
        running_crc  = start_crc();
    endfunction

    // Width in use: zero acts as one, anything above the datapath is clamped
    function int unsigned used_width();
        if (width_set == 0) return 1;
        if (width_set > ccrc_pkg::MAX_WIDTH) return ccrc_pkg::MAX_WIDTH;
        return width_set;
    endfunction

    function logic [63:0] low_ones(input int unsigned w);
        if (w >= 64) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // Reverse the low w bits
    function logic [63:0] mirror(input logic [63:0] v, input int unsigned w);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < w; i++) begin
            if (v[i]) r[w-1-i] = 1'b1;
        end
        return r;
    endfunction

    function logic [63:0] start_crc();
        int unsigned w;
        logic [63:0] v;
        w = used_width();
        v = init_set & low_ones(w);
        if (refl_in_set) v = mirror(v, w);
        return v;
    endfunction

    // Register write: known registers restart the running CRC, others do nothing
    function void write_setting(input logic [ccrc_pkg::IDX_W-1:0] idx,
                                input logic [63:0] value);
        case (idx)
            ccrc_pkg::REG_CRC_WIDTH:      width_set    = value[ccrc_pkg::CWID_W-1:0];
            ccrc_pkg::REG_POLYNOMIAL:     poly_set     = value;
            ccrc_pkg::REG_INITIAL_VALUE:  init_set     = value;
            ccrc_pkg::REG_REFLECT_INPUT:  refl_in_set  = value[0];
            ccrc_pkg::REG_REFLECT_OUTPUT: refl_out_set = value[0];
            ccrc_pkg::REG_FINAL_XOR:      xor_set      = value;
            default:                      return;
        endcase
        running_crc = start_crc();
    endfunction

    // Fold one accepted byte into the CRC; a last byte yields a finished CRC word
    function void note_byte(input logic [7:0] data, input logic last);
        int unsigned w;
        logic [63:0] m;
        logic [63:0] p;
        logic [63:0] c;
        logic        fb;
        w = used_width();
        m = low_ones(w);
        p = poly_set & m;
        c = running_crc & m;
        if (refl_in_set) begin
            p = mirror(p, w);
            c = c ^ {56'd0, data};
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
            end
        end else begin
            for (int i = 0; i < 8; i++) begin
                fb = c[w-1] ^ data[7-i];
                c  = (c << 1) & m;
                if (fb) c = c ^ p;
            end
        end
        c = c & m;
        running_crc = c;
        if (last) begin
            if (refl_in_set ^ refl_out_set) c = mirror(c, w);
            c = (c ^ xor_set) & m;
            expected_crcs.push_back(c);
            running_crc = start_crc();
        end
    endfunction

    // Compare one CRC word with the oldest one owed
    function void check_crc(input logic [63:0] got);
        logic [63:0] want;
        words_seen++;
        if (expected_crcs.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("crc word %0d: none expected, got %h", words_seen, got);
            return;
        end
        want = expected_crcs.pop_front();
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("crc word %0d: expected %h, got %h", words_seen, want, got);
        end
    endfunction
endclass

module tb_top;
    import ccrc_pkg::*;

    // Cycles without any word moving before the run is abandoned
    localparam int unsigned IDLE_LIMIT = 1000;
    // Register indexes with nothing behind them
    localparam logic [IDX_W-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [DATA_W-1:0]  i_data_byte;
    logic               i_last_byte;
    logic               out_valid;
    logic               out_stall;
    logic [CRC_W-1:0]   o_crc_value;

    crc_scoreboard sb;
    int unsigned   in_gap_cap;
    int unsigned   out_stall_cap;
    int unsigned   msg_left;
    int unsigned   idle_cycles;

    configurable_crc_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .o_crc_value (o_crc_value)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Handshake monitor and watchdog
    always @(posedge i_clk) begin
        logic took;
        took = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (in_valid === 1'b1 && in_stall === 1'b0) begin
                sb.note_byte(i_data_byte, i_last_byte);
                took = 1'b1;
            end
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                sb.check_crc(o_crc_value);
                took = 1'b1;
            end
        end
        idle_cycles = took ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall before each word is taken
    initial begin
        forever begin
            repeat ($urandom_range(0, out_stall_cap)) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
            do @(posedge i_clk); while (out_valid !== 1'b1);
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Settings value biased toward the extremes
    function automatic logic [63:0] setting_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return rand_word();
        endcase
    endfunction

    // Present one byte after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] data, input logic last);
        repeat ($urandom_range(0, in_gap_cap)) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid    <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (in_stall !== 1'b0);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_setting(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic [63:0] width, input logic [63:0] poly,
                             input logic [63:0] init, input logic [63:0] refl_in,
                             input logic [63:0] refl_out, input logic [63:0] fxor);
        write_reg(REG_CRC_WIDTH, width);
        write_reg(REG_POLYNOMIAL, poly);
        write_reg(REG_INITIAL_VALUE, init);
        write_reg(REG_REFLECT_INPUT, refl_in);
        write_reg(REG_REFLECT_OUTPUT, refl_out);
        write_reg(REG_FINAL_XOR, fxor);
    endtask

    // Stop sending, wait for every owed CRC word, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.expected_crcs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random settings; junk in unused upper bits of the narrow registers
    task automatic program_random();
        logic [6:0]  w;
        logic [63:0] junk;
        case ($urandom_range(0, 3))
            0:       w = 7'($urandom_range(1, 64));
            1:       w = 7'(1 << $urandom_range(0, 6));
            2:       w = 7'($urandom_range(0, 127));
            default: w = 7'($urandom_range(1, 16));
        endcase
        junk = rand_word();
        write_all({junk[63:7], w}, setting_word(), setting_word(), rand_word(), rand_word(),
                  setting_word());
    endtask

    // Messages of random length, mostly short; a message may run across calls
    task automatic run_messages(input int unsigned count);
        for (int k = 0; k < count; k++) begin
            if (msg_left == 0)
                msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                       : $urandom_range(1, 8);
            msg_left--;
            send_byte(8'($urandom_range(0, 255)), msg_left == 0);
        end
    endtask

    initial begin
        string digits;
        digits        = "123456789";
        sb            = new();
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        i_data_byte   = '0;
        i_last_byte   = 1'b0;
        out_stall     = 1'b0;
        in_gap_cap    = 3;
        out_stall_cap = 3;
        msg_left      = 0;
        idle_cycles   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings (CRC-32): check string, extreme bytes, two-byte message
        for (int k = 0; k < 9; k++) send_byte(digits[k], k == 8);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);

        // Width zero acts as one bit
        drain();
        write_all(64'd0, '1, '1, 64'd0, 64'd1, 64'h5);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b1);

        // Width above the maximum, junk above the reflect bit, no reflection
        drain();
        write_all('1, 64'h42F0_E1EB_A9EA_3693, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 64'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);

        // Full width, mixed reflection; spare index must not restart the message
        drain();
        write_all(64'd64, 64'hAD93_D235_94C9_35A9, '1, 64'd1, 64'd0, '1);
        send_byte(8'h31, 1'b0);
        drain();
        write_reg(SPARE_IDX_LO, '1);
        send_byte(8'h32, 1'b1);
        // A known register write abandons the message in progress
        send_byte(8'h33, 1'b0);
        drain();
        write_reg(REG_POLYNOMIAL, 64'hAD93_D235_94C9_35A9);
        send_byte(8'h34, 1'b1);

        // Narrow width with settings wider than the width
        drain();
        write_all(64'd8, 64'hABCD_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 64'd1,
                  64'h1234_5678_9ABC_DE55);
        send_byte(8'h7E, 1'b1);

        // Random phases, each under fresh settings and idling
        for (int ph = 0; ph < 13; ph++) begin
            in_gap_cap    = ($urandom_range(0, 3) == 0) ? 0 : 3;
            out_stall_cap = ($urandom_range(0, 3) == 0) ? 0 : 3;
            drain();
            program_random();
            run_messages(30);
            if ($urandom_range(0, 1) == 1) begin
                drain();
                write_reg(($urandom_range(0, 1) == 1) ? SPARE_IDX_LO : SPARE_IDX_HI,
                          rand_word());
            end
            run_messages(25);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.expected_crcs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ccrc_pkg.sv
rtl/configurable_crc_engine.sv
tb/sv/tb_top.sv
